// ----- sv/csm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Cartesian to spherical map.
// No dependencies.
package csm_pkg;

  localparam int SQRT_STEPS     = 32;
  localparam int TABLE_LEN      = 40;
  localparam int PRESCALE_SHIFT = 24;
  localparam int CORDIC_W       = 62;
  localparam int LANES          = 2;
  localparam int LANE_AZIM      = 0;
  localparam int LANE_POLAR     = 1;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] TQ_TURN      = 32'hC000_0000;

  // atan(2^-i) in binary turns
  localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef struct packed {
    logic mode3;
    logic zero;
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_pos;
    logic z_zero;
    logic z_neg;
  } csm_flags_t;

  typedef struct packed {
    csm_flags_t         flags;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } csm_sq_side_t;

  typedef struct packed {
    csm_flags_t  flags;
    logic [31:0] radius;
  } csm_cd_side_t;

endpackage

// ----- sv/csm_square.sv -----
`timescale 1ns / 1ps
// Front end: squares and sums of squares, two register stages.
// Depends on csm_pkg.
module csm_square import csm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  input  logic               mode3,
  output logic               out_vld,
  output logic [63:0]        rho_sq,
  output logic [63:0]        r_sq,
  output csm_sq_side_t       side
);

  logic signed [31:0] zm;
  logic signed [63:0] xx_nxt, yy_nxt, zz_nxt;
  logic [63:0]        xx_r, yy_r, zz_r;
  csm_sq_side_t       side1_nxt, side1_r, side2_r;
  logic               vld1_r, vld2_r;
  logic [63:0]        rho_sq_r, r_sq_r;

  assign zm     = mode3 ? z : 32'sd0;
  assign xx_nxt = x * x;
  assign yy_nxt = y * y;
  assign zz_nxt = zm * zm;

  always_comb begin
    side1_nxt.x            = x;
    side1_nxt.y            = y;
    side1_nxt.z            = zm;
    side1_nxt.flags.mode3  = mode3;
    side1_nxt.flags.x_zero = (x == 32'sd0);
    side1_nxt.flags.y_zero = (y == 32'sd0);
    side1_nxt.flags.z_zero = (zm == 32'sd0);
    side1_nxt.flags.x_neg  = x[31];
    side1_nxt.flags.y_pos  = !y[31] && (y != 32'sd0);
    side1_nxt.flags.z_neg  = zm[31];
    side1_nxt.flags.zero   = (x == 32'sd0) && (y == 32'sd0) && (zm == 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r   <= in_vld;
      xx_r     <= $unsigned(xx_nxt);
      yy_r     <= $unsigned(yy_nxt);
      zz_r     <= $unsigned(zz_nxt);
      side1_r  <= side1_nxt;
      vld2_r   <= vld1_r;
      rho_sq_r <= xx_r + yy_r;
      r_sq_r   <= xx_r + yy_r + zz_r;
      side2_r  <= side1_r;
    end
  end

  assign out_vld = vld2_r;
  assign rho_sq  = rho_sq_r;
  assign r_sq    = r_sq_r;
  assign side    = side2_r;

endmodule

// ----- sv/csm_isqrt.sv -----
`timescale 1ns / 1ps
// Pipelined rounded integer square roots of rho^2 and r^2, one result bit
// per stage plus a rounding stage. Depends on csm_pkg.
module csm_isqrt import csm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [63:0]  rho_sq,
  input  logic [63:0]  r_sq,
  input  csm_sq_side_t in_side,
  output logic         out_vld,
  output logic [32:0]  rho,
  output logic [31:0]  radius,
  output csm_sq_side_t out_side
);

  logic [63:0]  pn_r [SQRT_STEPS];
  logic [63:0]  pq_r [SQRT_STEPS];
  logic [63:0]  rn_r [SQRT_STEPS];
  logic [63:0]  rq_r [SQRT_STEPS];
  csm_sq_side_t side_r [SQRT_STEPS];
  logic         vld_r [SQRT_STEPS];

  logic [32:0]  rho_r, rad_r;
  csm_sq_side_t oside_r;
  logic         ovld_r;
  logic [32:0]  rho_nxt, rad_nxt;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]  pn_i, pq_i, rn_i, rq_i;
    logic [63:0]  pt, rt;
    logic [63:0]  pn_nxt, pq_nxt, rn_nxt, rq_nxt;
    csm_sq_side_t side_i;
    logic         vld_i;

    if (k == 0) begin : g_first
      assign pn_i   = rho_sq;
      assign pq_i   = 64'd0;
      assign rn_i   = r_sq;
      assign rq_i   = 64'd0;
      assign side_i = in_side;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign pn_i   = pn_r[k-1];
      assign pq_i   = pq_r[k-1];
      assign rn_i   = rn_r[k-1];
      assign rq_i   = rq_r[k-1];
      assign side_i = side_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign pt = pq_i + BIT;
    assign rt = rq_i + BIT;

    always_comb begin
      if (pn_i >= pt) begin
        pn_nxt = pn_i - pt;
        pq_nxt = (pq_i >> 1) + BIT;
      end else begin
        pn_nxt = pn_i;
        pq_nxt = pq_i >> 1;
      end
      if (rn_i >= rt) begin
        rn_nxt = rn_i - rt;
        rq_nxt = (rq_i >> 1) + BIT;
      end else begin
        rn_nxt = rn_i;
        rq_nxt = rq_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k]  <= vld_i;
        pn_r[k]   <= pn_nxt;
        pq_r[k]   <= pq_nxt;
        rn_r[k]   <= rn_nxt;
        rq_r[k]   <= rq_nxt;
        side_r[k] <= side_i;
      end
    end
  end

  // round to nearest: bump when remainder exceeds root
  assign rho_nxt = pq_r[SQRT_STEPS-1][32:0]
                 + {32'd0, (pn_r[SQRT_STEPS-1] > pq_r[SQRT_STEPS-1])};
  assign rad_nxt = rq_r[SQRT_STEPS-1][32:0]
                 + {32'd0, (rn_r[SQRT_STEPS-1] > rq_r[SQRT_STEPS-1])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r  <= vld_r[SQRT_STEPS-1];
      rho_r   <= rho_nxt;
      rad_r   <= rad_nxt;
      oside_r <= side_r[SQRT_STEPS-1];
    end
  end

  assign out_vld  = ovld_r;
  assign rho      = rho_r;
  assign radius   = rad_r[31:0];
  assign out_side = oside_r;

endmodule

// ----- sv/csm_cordic.sv -----
`timescale 1ns / 1ps
// Two-lane pipelined vectoring CORDIC, atan2(b, a) in binary turns.
// Pre-rotation stage, then one micro-rotation per stage. Depends on csm_pkg.
module csm_cordic import csm_pkg::*; #(
  parameter int STEPS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [32:0] a [LANES],
  input  logic signed [32:0] b [LANES],
  input  csm_cd_side_t       in_side,
  output logic               out_vld,
  output logic [31:0]        ang [LANES],
  output csm_cd_side_t       out_side
);

  localparam int N = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

  logic signed [CORDIC_W-1:0] x_r   [N+1][LANES];
  logic signed [CORDIC_W-1:0] y_r   [N+1][LANES];
  logic [31:0]                ang_r [N+1][LANES];
  csm_cd_side_t               side_r [N+1];
  logic                       vld_r  [N+1];

  // pre-rotation: scale up, flip by half a turn when a is negative
  for (genvar l = 0; l < LANES; l++) begin : g_pre
    logic signed [CORDIC_W-1:0] xa, yb;
    assign xa = CORDIC_W'(a[l]) <<< PRESCALE_SHIFT;
    assign yb = CORDIC_W'(b[l]) <<< PRESCALE_SHIFT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xa[CORDIC_W-1]) begin
          x_r[0][l]   <= -xa;
          y_r[0][l]   <= -yb;
          ang_r[0][l] <= HALF_TURN;
        end else begin
          x_r[0][l]   <= xa;
          y_r[0][l]   <= yb;
          ang_r[0][l] <= 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0]  <= in_vld;
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [CORDIC_W-1:0] xs, ys;
      assign xs = x_r[i][l] >>> i;
      assign ys = y_r[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          if (!y_r[i][l][CORDIC_W-1]) begin
            x_r[i+1][l]   <= x_r[i][l] + ys;
            y_r[i+1][l]   <= y_r[i][l] - xs;
            ang_r[i+1][l] <= ang_r[i][l] + ATAN_TURNS[i];
          end else begin
            x_r[i+1][l]   <= x_r[i][l] - ys;
            y_r[i+1][l]   <= y_r[i][l] + xs;
            ang_r[i+1][l] <= ang_r[i][l] - ATAN_TURNS[i];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1]  <= vld_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_side = side_r[N];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign ang[l] = ang_r[N][l];
  end

endmodule

// ----- sv/cartesian_to_spherical_map.sv -----
`timescale 1ns / 1ps
// Cartesian to spherical map: Q15.16 (x,y,z) in, radius and two angles out.
// Datapath: squares, the 32-stage bit-per-stage square root with its rounding
// stage, then the CORDIC chain and a final register stage.
// Throughput one word per cycle; the whole pipe holds while a result is stalled.
// Reset (rst_n low, synchronous) empties the pipe and sets 3D mode.
module cartesian_to_spherical_map import csm_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_radius,
  output logic [31:0]        out_polar_angle,
  output logic [31:0]        out_azimuth_angle,
  output logic               out_zero_radius
);

  // mode register, 1 = spherical, 0 = polar in the xy plane
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // One enable for every stage: the pipe moves unless a result is held.
  logic en;
  logic ovld_r;
  assign en       = !ovld_r || !out_stall;
  assign in_stall = !en;

  // squares and sums
  logic         sq_vld;
  logic [63:0]  rho_sq, r_sq;
  csm_sq_side_t sq_side;

  csm_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .x      (in_coord_x),
    .y      (in_coord_y),
    .z      (in_coord_z),
    .mode3  (mode_r),
    .out_vld(sq_vld),
    .rho_sq (rho_sq),
    .r_sq   (r_sq),
    .side   (sq_side)
  );

  // rho and r roots
  logic         rt_vld;
  logic [32:0]  rho;
  logic [31:0]  radius;
  csm_sq_side_t rt_side;

  csm_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .rho_sq  (rho_sq),
    .r_sq    (r_sq),
    .in_side (sq_side),
    .out_vld (rt_vld),
    .rho     (rho),
    .radius  (radius),
    .out_side(rt_side)
  );

  // azimuth lane: atan2(y, x); polar lane: atan2(rho, z)
  logic signed [32:0] cd_a [LANES];
  logic signed [32:0] cd_b [LANES];
  logic [31:0]        cd_ang [LANES];
  csm_cd_side_t       cd_in_side, cd_side;
  logic               cd_vld;

  assign cd_a[LANE_AZIM]  = 33'(rt_side.x);
  assign cd_b[LANE_AZIM]  = 33'(rt_side.y);
  assign cd_a[LANE_POLAR] = 33'(rt_side.z);
  assign cd_b[LANE_POLAR] = $signed(rho);
  assign cd_in_side.flags  = rt_side.flags;
  assign cd_in_side.radius = radius;

  csm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (rt_vld),
    .a       (cd_a),
    .b       (cd_b),
    .in_side (cd_in_side),
    .out_vld (cd_vld),
    .ang     (cd_ang),
    .out_side(cd_side)
  );

  // Final stage: exact angles on axes and planes, polar saturation.
  csm_flags_t  f;
  logic [31:0] azim_nxt, polar_nxt, pc;
  logic [31:0] rad_r, polar_r, azim_r;
  logic        zero_r;

  assign f  = cd_side.flags;
  assign pc = cd_ang[LANE_POLAR];

  always_comb begin
    if (f.x_zero && f.y_zero) begin
      azim_nxt = 32'd0;
    end else if (f.y_zero) begin
      azim_nxt = f.x_neg ? HALF_TURN : 32'd0;
    end else if (f.x_zero) begin
      azim_nxt = f.y_pos ? QUARTER_TURN : TQ_TURN;
    end else begin
      azim_nxt = cd_ang[LANE_AZIM];
    end

    if (!f.mode3 || f.zero) begin
      polar_nxt = 32'd0;
    end else if (f.x_zero && f.y_zero) begin
      polar_nxt = f.z_neg ? HALF_TURN : 32'd0;      // on the z axis
    end else if (f.z_zero) begin
      polar_nxt = QUARTER_TURN;
    end else if (pc > HALF_TURN) begin
      polar_nxt = (pc >= TQ_TURN) ? 32'd0 : HALF_TURN;  // overshoot
    end else begin
      polar_nxt = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r  <= cd_vld;
      rad_r   <= cd_side.radius;
      polar_r <= polar_nxt;
      azim_r  <= azim_nxt;
      zero_r  <= f.zero;
    end
  end

  assign out_valid         = ovld_r;
  assign out_radius        = rad_r;
  assign out_polar_angle   = polar_r;
  assign out_azimuth_angle = azim_r;
  assign out_zero_radius   = zero_r;

endmodule

// ----- sv/csm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the Cartesian to spherical map, bound to the top.
// Depends on cartesian_to_spherical_map.
module csm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_radius,
  input logic [31:0] out_polar_angle,
  input logic [31:0] out_azimuth_angle,
  input logic        out_zero_radius
);

  // held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // input only backs up behind a held result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_radius |->
      out_radius == 32'd0 && out_polar_angle == 32'd0 && out_azimuth_angle == 32'd0)
    else $error("origin word with nonzero fields");

  a_polar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polar_angle <= 32'h8000_0000 &&
      (out_zero_radius || out_radius != 32'd0))
    else $error("polar angle beyond half turn or radius lost");

endmodule

bind cartesian_to_spherical_map csm_checker u_csm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_radius       (out_radius),
  .out_polar_angle  (out_polar_angle),
  .out_azimuth_angle(out_azimuth_angle),
  .out_zero_radius  (out_zero_radius)
);

// ----- verif/cartesian_to_spherical_map_tb.sv -----
`timescale 1ns / 1ps
// Testbench for cartesian_to_spherical_map: directed and random points, checked
// against an in-bench bit-exact model of the radius, polar angle, azimuth and zero flag.
// Depends on csm_pkg and the block itself.
module cartesian_to_spherical_map_tb import csm_pkg::*;;

  localparam int STEPS     = 32;
  localparam int LATENCY   = 37 + STEPS;
  localparam int N_RANDOM  = 1700;

  typedef struct {
    logic [31:0] radius;
    logic [31:0] polar;
    logic [31:0] azim;
    logic        zero;
  } sph_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_radius, out_polar_angle, out_azimuth_angle;
  logic out_zero_radius;

  cartesian_to_spherical_map #(.CORDIC_STEPS(STEPS)) uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mode as seen by the words being sent; the bench only changes it when idle
  logic   mode3 = 1'b1;
  point_t pending_points[$];
  sph_t   expected_sph[$];
  int     errors = 0;
  bit     hold_send = 1'b0;

  // rounded integer square root of a 64-bit sum of squares
  function automatic logic [63:0] root_rounded(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (n > res) res++;
    return res;
  endfunction

  // vectoring CORDIC, atan2(b, a) in binary turns
  function automatic logic [31:0] turns_atan2(longint b, longint a);
    longint vx, vy, sx, sy;
    logic [31:0] ang;
    vx = a <<< PRESCALE_SHIFT;
    vy = b <<< PRESCALE_SHIFT;
    ang = 0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = HALF_TURN;
    end
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx += sy; vy -= sx; ang += ATAN_TURNS[i];
      end else begin
        vx -= sy; vy += sx; ang -= ATAN_TURNS[i];
      end
    end
    return ang;
  endfunction

  function automatic sph_t spherical_of(point_t p, logic m3);
    longint x, y, z;
    logic [63:0] rho_sq, r_sq, rho;
    sph_t s;
    x = p.x;
    y = p.y;
    z = m3 ? longint'(p.z) : 0;
    rho_sq = x * x + y * y;
    r_sq = rho_sq + z * z;
    rho = root_rounded(rho_sq);
    s.radius = 32'(root_rounded(r_sq));
    s.zero = (r_sq == 0);
    s.polar = 0;
    if (x == 0 && y == 0) s.azim = 0;
    else if (y == 0) s.azim = (x < 0) ? HALF_TURN : 32'd0;
    else if (x == 0) s.azim = (y > 0) ? QUARTER_TURN : TQ_TURN;
    else s.azim = turns_atan2(y, x);
    if (m3 && !s.zero) begin
      if (rho == 0) s.polar = (z < 0) ? HALF_TURN : 32'd0;
      else if (z == 0) s.polar = QUARTER_TURN;
      else begin
        s.polar = turns_atan2(longint'(rho), z);
        // overshoot past either end is clamped
        if (s.polar > HALF_TURN) s.polar = (s.polar >= TQ_TURN) ? 32'd0 : HALF_TURN;
      end
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // mostly short gaps, occasionally long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3: return $signed(32'($urandom_range(0, 2047))) - 1024;
      4: return $signed($urandom) >>> $urandom_range(0, 24);
      default: return $signed($urandom);
    endcase
  endfunction

  // driver: a word moves when valid is high and stall is low; the word on
  // the bus stays at the front of the queue until it is taken
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        void'(pending_points.pop_front());
        expected_sph.push_back(spherical_of('{in_coord_x, in_coord_y, in_coord_z}, mode3));
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!hold_send && pending_points.size() > 0) begin
        point_t p;
        p = pending_points[0];
        in_valid <= 1'b1;
        in_coord_x <= p.x;
        in_coord_y <= p.y;
        in_coord_z <= p.z;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sph.size() == 0) begin
          $display("unexpected word at %0t", $time);
          errors++;
        end else begin
          sph_t e;
          e = expected_sph.pop_front();
          if (out_radius !== e.radius) report_mismatch("radius", out_radius, e.radius);
          if (out_polar_angle !== e.polar)
            report_mismatch("polar", out_polar_angle, e.polar);
          if (out_azimuth_angle !== e.azim)
            report_mismatch("azimuth", out_azimuth_angle, e.azim);
          if (out_zero_radius !== e.zero)
            report_mismatch("zero_radius", 32'(out_zero_radius), 32'(e.zero));
        end
      end
      out_stall <= (gap_len() != 0);
    end
  end

  task automatic wait_drained();
    while (pending_points.size() != 0 || in_valid || expected_sph.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode3 = m;
  endtask

  task automatic add_point(logic signed [31:0] x, y, z);
    pending_points.push_back('{x, y, z});
  endtask

  task automatic directed_set();
    add_point(0, 0, 0);                                   // origin
    add_point(0, 0, 32'sh0001_0000);                      // +z axis
    add_point(0, 0, -32'sh0001_0000);                     // -z axis
    add_point(32'sh0002_0000, 0, 0);                      // axes and planes
    add_point(-32'sh0002_0000, 0, 5);
    add_point(0, 32'sh0003_0000, -7);
    add_point(0, -32'sh0003_0000, 0);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    add_point(1, 1, 32'sh7FFF_FFFF);                      // polar near 0
    add_point(1, -1, 32'sh8000_0000);                     // polar near half turn
    add_point(-1, -1, 1);
    add_point(1, 0, 0);
    add_point(-1, 1, -1);
    add_point(32'sh1234_5678, -32'sh0765_4321, 32'sh0ABC_DEF0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    directed_set();
    wait_drained();
    write_mode(1'b0);
    directed_set();
    wait_drained();
    write_mode(1'b1);
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < N_RANDOM / 4; i++)
        add_point(rand_coord(), rand_coord(), rand_coord());
      if (phase == 1) begin
        // sender holds off until the pipe empties
        while (pending_points.size() > 200) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_sph.size() != 0) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
      write_mode(phase[0]);
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
